>>> rtl/core/midi_track_note_extractor_defines.svh
// assertion macros shared by the table, parser and output buffer files
`ifndef MIDI_TRACK_NOTE_EXTRACTOR_DEFINES_SVH
`define MIDI_TRACK_NOTE_EXTRACTOR_DEFINES_SVH

// checked outside reset
`define MTE_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every rising edge, reset included
`define MTE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/core/mte_pkg.sv
package mte_pkg;

    localparam int CHANNELS_DEF  = 16;
    localparam int PITCHES_DEF   = 128;
    localparam int TIME_BITS_DEF = 48;

    localparam int DATA_W     = 8;
    localparam int CH_W       = 4;
    localparam int PITCH_W    = 7;
    localparam int OUT_TIME_W = 48;
    localparam int VARLEN_W   = 32;
    localparam int EPOCH_W    = 8;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 112;

    localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
    localparam logic [3:0] NIB_POLY_PRESS = 4'hA;
    localparam logic [3:0] NIB_CONTROL    = 4'hB;
    localparam logic [3:0] NIB_PITCH_BEND = 4'hE;
    localparam logic [7:0] ST_SYSEX       = 8'hF0;
    localparam logic [7:0] ST_META        = 8'hFF;

    typedef enum logic [2:0] {
        PH_DELTA,
        PH_EVENT,
        PH_DATA1,
        PH_DATA2,
        PH_LEN,
        PH_SKIP
    } phase_t;

    typedef struct packed {
        logic [CH_W-1:0]       channel;
        logic [PITCH_W-1:0]    pitch;
        logic [OUT_TIME_W-1:0] start_time;
        logic [OUT_TIME_W-1:0] end_time;
        logic                  is_error;
    } note_result_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_open;
        logic new_track;
    } tbl_ctrl_t;

endpackage

>>> rtl/core/mte_ram.sv
module mte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                         aclk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/mte_table.sv
`include "midi_track_note_extractor_defines.svh"

module mte_table import mte_pkg::*; #(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int PITCHES   = PITCHES_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                                                     aclk,
    input  logic                                                     aresetn,
    input  tbl_ctrl_t                                                ctrl,
    input  logic [((CHANNELS * PITCHES > 1) ? $clog2(CHANNELS * PITCHES) : 1)-1:0] rd_addr,
    input  logic [((CHANNELS * PITCHES > 1) ? $clog2(CHANNELS * PITCHES) : 1)-1:0] wr_addr,
    input  logic [TIME_BITS-1:0]                                     wr_start,
    output logic                                                     hit,
    output logic [TIME_BITS-1:0]                                     hit_start,
    output logic                                                     sweep_busy
);

    localparam int DEPTH  = CHANNELS * PITCHES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W = EPOCH_W + 1 + TIME_BITS;

    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic               sweep_busy_reg, sweep_busy_next;
    logic [ADDR_W-1:0]  sweep_addr_reg, sweep_addr_next;

    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [WORD_W-1:0]  ram_wr_data;
    logic [WORD_W-1:0]  ram_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg      <= '0;
            sweep_busy_reg <= 1'b1;
            sweep_addr_reg <= '0;
        end else begin
            epoch_reg      <= epoch_next;
            sweep_busy_reg <= sweep_busy_next;
            sweep_addr_reg <= sweep_addr_next;
        end
    end

    // epoch tag retires old entries at track start; a wrap forces a full sweep
    always_comb begin
        epoch_next      = epoch_reg;
        sweep_busy_next = sweep_busy_reg;
        sweep_addr_next = sweep_addr_reg;
        if (sweep_busy_reg) begin
            if (sweep_addr_reg == ADDR_W'(DEPTH - 1)) begin
                sweep_busy_next = 1'b0;
            end
            sweep_addr_next = sweep_addr_reg + 1'b1;
        end
        if (ctrl.new_track) begin
            epoch_next = epoch_reg + 1'b1;
            if (epoch_reg == '1) begin
                sweep_busy_next = 1'b1;
                sweep_addr_next = '0;
            end
        end
    end

    always_comb begin
        ram_wr_en   = sweep_busy_reg || ctrl.wr_en;
        ram_wr_addr = sweep_busy_reg ? sweep_addr_reg : wr_addr;
        ram_wr_data = sweep_busy_reg ? '0 : {epoch_reg, ctrl.wr_open, wr_start};
    end

    mte_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ctrl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    assign hit        = ram_rd_data[TIME_BITS] &&
                        (ram_rd_data[WORD_W-1 -: EPOCH_W] == epoch_reg);
    assign hit_start  = ram_rd_data[TIME_BITS-1:0];
    assign sweep_busy = sweep_busy_reg;

    `MTE_ASSERT_CLK(a_no_write_in_sweep, sweep_busy_reg |-> !ctrl.wr_en, "table write during sweep")
    `MTE_ASSERT_CLK(a_no_read_in_sweep, sweep_busy_reg |-> !ctrl.rd_en, "table read during sweep")

endmodule

>>> rtl/core/mte_parser.sv
`include "midi_track_note_extractor_defines.svh"

module mte_parser import mte_pkg::*; #(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int PITCHES   = PITCHES_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                                                     aclk,
    input  logic                                                     aresetn,
    input  logic                                                     in_acc,
    input  logic [DATA_W-1:0]                                        in_byte,
    input  logic                                                     in_track_start,
    output tbl_ctrl_t                                                tbl_ctrl,
    output logic [((CHANNELS * PITCHES > 1) ? $clog2(CHANNELS * PITCHES) : 1)-1:0] rd_addr,
    output logic [((CHANNELS * PITCHES > 1) ? $clog2(CHANNELS * PITCHES) : 1)-1:0] wr_addr,
    output logic [TIME_BITS-1:0]                                     wr_start,
    input  logic                                                     tbl_hit,
    input  logic [TIME_BITS-1:0]                                     tbl_start,
    output logic                                                     res_valid,
    output note_result_t                                             res
);

    localparam int DEPTH  = CHANNELS * PITCHES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = CH_W + PITCH_W + 1;

    phase_t               phase_reg, phase_next, ph_eff;
    logic [VARLEN_W-1:0]  delta_reg, delta_next, delta_eff;
    logic [TIME_BITS-1:0] time_reg, time_next, time_eff;
    logic [DATA_W-1:0]    status_reg, status_next, status_eff;
    logic [PITCH_W-1:0]   first_reg, first_next, first_eff;
    logic [VARLEN_W-1:0]  skip_reg, skip_next, skip_eff;
    logic                 halted_reg, halted_next, halted_eff;
    logic                 pend_reg, pend_next;
    logic [ADDR_W-1:0]    pend_addr_reg, pend_addr_next;

    logic [VARLEN_W-1:0]  delta_shift, skip_shift, skip_dec;
    logic [TIME_BITS:0]   time_sum;
    logic [TIME_BITS-1:0] time_sat;
    logic [3:0]           nib;
    logic [CH_W-1:0]      ch;
    logic [PITCH_W-1:0]   pitch_in;
    logic                 in_range, note_class, data2_class;
    logic [IDX_W-1:0]     idx;
    phase_t               fb_phase;
    logic [VARLEN_W-1:0]  fb_skip;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_DELTA;
            delta_reg  <= '0;
            time_reg   <= '0;
            status_reg <= '0;
            first_reg  <= '0;
            skip_reg   <= '0;
            halted_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            delta_reg  <= delta_next;
            time_reg   <= time_next;
            status_reg <= status_next;
            first_reg  <= first_next;
            skip_reg   <= skip_next;
            halted_reg <= halted_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= pend_addr_next;
    end

    // track start clears the parse state before the byte is parsed
    always_comb begin
        ph_eff     = in_track_start ? PH_DELTA : phase_reg;
        delta_eff  = in_track_start ? '0 : delta_reg;
        time_eff   = in_track_start ? '0 : time_reg;
        status_eff = in_track_start ? '0 : status_reg;
        first_eff  = in_track_start ? '0 : first_reg;
        skip_eff   = in_track_start ? '0 : skip_reg;
        halted_eff = in_track_start ? 1'b0 : halted_reg;
    end

    // varlen shifts and saturating time add
    always_comb begin
        delta_shift = {delta_eff[VARLEN_W-8:0], in_byte[6:0]};
        skip_shift  = {skip_eff[VARLEN_W-8:0], in_byte[6:0]};
        skip_dec    = (skip_eff != '0) ? skip_eff - 1'b1 : '0;
        time_sum    = {1'b0, time_eff} + (TIME_BITS + 1)'(delta_shift);
        time_sat    = time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];
    end

    // first data byte under running status
    always_comb begin
        nib         = status_eff[7:4];
        ch          = status_eff[3:0];
        pitch_in    = in_byte[6:0];
        in_range    = ({1'b0, ch} < (CH_W + 1)'(CHANNELS)) &&
                      ({1'b0, pitch_in} < (PITCH_W + 1)'(PITCHES));
        note_class  = (nib == NIB_NOTE_OFF) || (nib == NIB_NOTE_ON);
        data2_class = note_class || (nib == NIB_POLY_PRESS) ||
                      (nib == NIB_CONTROL) || (nib == NIB_PITCH_BEND);
        idx         = IDX_W'(ch) * IDX_W'(PITCHES) + IDX_W'(pitch_in);
        rd_addr     = idx[ADDR_W-1:0];
        fb_skip     = skip_eff;
        if (data2_class) begin
            fb_phase = PH_DATA2;
        end else if (status_eff == ST_SYSEX) begin
            fb_skip  = VARLEN_W'(pitch_in);
            fb_phase = (pitch_in != '0) ? PH_SKIP : PH_DELTA;
        end else if (status_eff == ST_META) begin
            fb_skip  = '0;
            fb_phase = PH_LEN;
        end else begin
            fb_phase = PH_DELTA;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        delta_next     = delta_reg;
        time_next      = time_reg;
        status_next    = status_reg;
        first_next     = first_reg;
        skip_next      = skip_reg;
        halted_next    = halted_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        tbl_ctrl       = '0;
        res_valid      = 1'b0;
        res            = '0;
        if (in_acc) begin
            tbl_ctrl.new_track = in_track_start;
            phase_next  = ph_eff;
            delta_next  = delta_eff;
            time_next   = time_eff;
            status_next = status_eff;
            first_next  = first_eff;
            skip_next   = skip_eff;
            halted_next = halted_eff;
            if (!halted_eff) begin
                case (ph_eff)
                    PH_DELTA: begin
                        delta_next = delta_shift;
                        if (!in_byte[7]) begin
                            time_next  = time_sat;
                            delta_next = '0;
                            phase_next = PH_EVENT;
                        end
                    end
                    PH_EVENT, PH_DATA1: begin
                        if (in_byte[7]) begin
                            if (ph_eff == PH_EVENT) begin
                                status_next = in_byte;
                                phase_next  = PH_DATA1;
                            end else begin
                                res_valid      = 1'b1;
                                res.is_error   = 1'b1;
                                halted_next    = 1'b1;
                                phase_next     = PH_DELTA;
                            end
                        end else begin
                            first_next     = pitch_in;
                            skip_next      = fb_skip;
                            phase_next     = fb_phase;
                            pend_next      = note_class && in_range;
                            pend_addr_next = rd_addr;
                            tbl_ctrl.rd_en = note_class && in_range;
                        end
                    end
                    PH_DATA2: begin
                        if (pend_reg) begin
                            tbl_ctrl.wr_en   = 1'b1;
                            tbl_ctrl.wr_open = (nib == NIB_NOTE_ON) && (in_byte != '0);
                            res_valid        = tbl_hit;
                        end
                        res.channel    = ch;
                        res.pitch      = first_eff;
                        res.start_time = OUT_TIME_W'(tbl_start);
                        res.end_time   = OUT_TIME_W'(time_eff);
                        pend_next      = 1'b0;
                        phase_next     = PH_DELTA;
                    end
                    PH_LEN: begin
                        skip_next = skip_shift;
                        if (!in_byte[7]) begin
                            phase_next = (skip_shift != '0) ? PH_SKIP : PH_DELTA;
                        end
                    end
                    PH_SKIP: begin
                        skip_next = skip_dec;
                        if (skip_dec == '0) begin
                            phase_next = PH_DELTA;
                        end
                    end
                    default: begin
                        phase_next = PH_DELTA;
                    end
                endcase
            end
        end
        if (!res_valid) begin
            res = '0;
        end
    end

    assign wr_addr  = pend_addr_reg;
    assign wr_start = time_eff;

    `MTE_ASSERT_CLK(a_rd_wr_excl, !(tbl_ctrl.rd_en && tbl_ctrl.wr_en), "table read and write in one beat")
    `MTE_ASSERT_CLK(a_halt_silent, halted_reg && !in_track_start |-> !res_valid, "result while halted")
    `MTE_ASSERT_CLK(a_write_needs_pend, tbl_ctrl.wr_en |-> pend_reg && phase_reg == PH_DATA2, "table write without pending lookup")

endmodule

>>> rtl/core/mte_out_buf.sv
`include "midi_track_note_extractor_defines.svh"

module mte_out_buf import mte_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  note_result_t push_data,
    output logic         full,
    output logic         m_valid,
    input  logic         m_ready,
    output note_result_t m_data
);

    logic         main_valid_reg, main_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    note_result_t main_reg, main_next;
    note_result_t skid_reg, skid_next;
    logic         pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    always_comb begin
        pop             = main_valid_reg && m_ready;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop) begin
            main_valid_next = skid_valid_reg;
            main_next       = skid_reg;
            skid_valid_next = 1'b0;
        end
        if (push) begin
            if (!main_valid_next) begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    assign full    = skid_valid_reg;
    assign m_valid = main_valid_reg;
    assign m_data  = main_reg;

    `MTE_ASSERT_CLK(a_no_overflow, push |-> !skid_valid_reg, "push into full skid stage")
    `MTE_ASSERT_ALWAYS(a_skid_behind_main, skid_valid_reg |-> main_valid_reg, "skid holds beat ahead of main")

endmodule

>>> rtl/core/midi_track_note_extractor.sv
// channel  dir  tdata                          tuser
// s_       in   data_byte[7:0]                 track_start
// m_       out  channel pitch start end (107)  is_error
//
// one byte per cycle while s_tready is high; a note lookup is read one byte ahead and written back
// at the velocity byte, so the table ram port sets the pace
// after reset, and on every 256th track start, the table's channels * pitches entries
// (2048 by default) are swept clear with s_tready low
// a two-beat output stage keeps s_tready high while one result is stalled
// results are registered in the output stage after the closing byte
module midi_track_note_extractor import mte_pkg::*; #(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int PITCHES   = PITCHES_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // data_byte
    input  logic                 s_tuser,  // track_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // channel, pitch, start_time, end_time, zero pad
    output logic                 m_tuser   // is_error
);

    localparam int DEPTH  = CHANNELS * PITCHES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                 in_acc;
    tbl_ctrl_t            tbl_ctrl;
    logic [ADDR_W-1:0]    rd_addr, wr_addr;
    logic [TIME_BITS-1:0] wr_start, tbl_start;
    logic                 tbl_hit, sweep_busy;
    logic                 res_valid, out_full;
    note_result_t         res, m_res;

    assign s_tready = !out_full && !sweep_busy;
    assign in_acc   = s_tvalid && s_tready;

    mte_parser #(
        .CHANNELS  (CHANNELS),
        .PITCHES   (PITCHES),
        .TIME_BITS (TIME_BITS)
    ) u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_acc         (in_acc),
        .in_byte        (s_tdata[DATA_W-1:0]),
        .in_track_start (s_tuser),
        .tbl_ctrl       (tbl_ctrl),
        .rd_addr        (rd_addr),
        .wr_addr        (wr_addr),
        .wr_start       (wr_start),
        .tbl_hit        (tbl_hit),
        .tbl_start      (tbl_start),
        .res_valid      (res_valid),
        .res            (res)
    );

    mte_table #(
        .CHANNELS  (CHANNELS),
        .PITCHES   (PITCHES),
        .TIME_BITS (TIME_BITS)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (tbl_ctrl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .wr_start   (wr_start),
        .hit        (tbl_hit),
        .hit_start  (tbl_start),
        .sweep_busy (sweep_busy)
    );

    mte_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .full      (out_full),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (m_res)
    );

    assign m_tdata = M_TDATA_W'({m_res.end_time, m_res.start_time, m_res.pitch, m_res.channel});
    assign m_tuser = m_res.is_error;

endmodule

>>> tb/note_checker.sv
`timescale 1ns / 1ps
module note_checker import mte_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,
    output int                   mismatches,
    output int                   pending
);

    localparam int SLOTS = CHANNELS_DEF * PITCHES_DEF;
    localparam int P_LO  = CH_W;
    localparam int S_LO  = CH_W + PITCH_W;
    localparam int E_LO  = S_LO + OUT_TIME_W;
    localparam logic [TIME_BITS_DEF-1:0] TIME_MAX = '1;

    phase_t                   phase;
    logic [VARLEN_W-1:0]      delta_acc;
    logic [VARLEN_W-1:0]      skip_cnt;
    logic [TIME_BITS_DEF-1:0] now;
    logic [7:0]               run_st;
    logic [PITCH_W-1:0]       key;
    bit                       halted;
    bit                       open_q [SLOTS];
    logic [TIME_BITS_DEF-1:0] began [SLOTS];
    note_result_t             finished_q [$];

    task automatic clear_track();
        phase     = PH_DELTA;
        delta_acc = '0;
        skip_cnt  = '0;
        now       = '0;
        run_st    = '0;
        key       = '0;
        halted    = 1'b0;
        for (int i = 0; i < SLOTS; i++) open_q[i] = 1'b0;
    endtask

    task automatic finish_note(input logic [CH_W-1:0] ch);
        note_result_t r;
        if (open_q[{ch, key}]) begin
            open_q[{ch, key}] = 1'b0;
            r.channel    = ch;
            r.pitch      = key;
            r.start_time = began[{ch, key}];
            r.end_time   = now;
            r.is_error   = 1'b0;
            finished_q   = {finished_q, r};
        end
    endtask

    task automatic take_first(input logic [7:0] d);
        logic [3:0] nib;
        nib = run_st[7:4];
        key = d[6:0];
        if (nib == NIB_NOTE_OFF || nib == NIB_NOTE_ON || nib == NIB_POLY_PRESS ||
            nib == NIB_CONTROL || nib == NIB_PITCH_BEND) begin
            phase = PH_DATA2;
        end else if (run_st == ST_SYSEX) begin
            skip_cnt = VARLEN_W'(d[6:0]);
            phase    = (skip_cnt != 0) ? PH_SKIP : PH_DELTA;
        end else if (run_st == ST_META) begin
            skip_cnt = '0;
            phase    = PH_LEN;
        end else begin
            phase = PH_DELTA;
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic ts);
        logic [TIME_BITS_DEF:0] sum;
        logic [CH_W-1:0]        ch;
        note_result_t           r;
        if (ts) clear_track();
        if (!halted) begin
            case (phase)
                PH_DELTA: begin
                    delta_acc = {delta_acc[VARLEN_W-8:0], b[6:0]};
                    if (!b[7]) begin
                        sum = {1'b0, now} + (TIME_BITS_DEF + 1)'(delta_acc);
                        now = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_BITS_DEF-1:0];
                        delta_acc = '0;
                        phase = PH_EVENT;
                    end
                end
                PH_EVENT: begin
                    if (b[7]) begin
                        run_st = b;
                        phase  = PH_DATA1;
                    end else begin
                        take_first(b);
                    end
                end
                PH_DATA1: begin
                    if (b[7]) begin
                        r = '0;
                        r.is_error = 1'b1;
                        finished_q = {finished_q, r};
                        halted = 1'b1;
                        phase  = PH_DELTA;
                    end else begin
                        take_first(b);
                    end
                end
                PH_DATA2: begin
                    ch = run_st[3:0];
                    if (run_st[7:4] == NIB_NOTE_OFF) begin
                        finish_note(ch);
                    end else if (run_st[7:4] == NIB_NOTE_ON) begin
                        finish_note(ch);
                        if (b != 0) begin
                            open_q[{ch, key}] = 1'b1;
                            began[{ch, key}]  = now;
                        end
                    end
                    phase = PH_DELTA;
                end
                PH_LEN: begin
                    skip_cnt = {skip_cnt[VARLEN_W-8:0], b[6:0]};
                    if (!b[7]) phase = (skip_cnt != 0) ? PH_SKIP : PH_DELTA;
                end
                PH_SKIP: begin
                    if (skip_cnt > 0) skip_cnt = skip_cnt - 1'b1;
                    if (skip_cnt == 0) phase = PH_DELTA;
                end
                default: begin
                    phase = PH_DELTA;
                end
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch on %0s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_beat();
        note_result_t want;
        if (finished_q.size() == 0) begin
            report_mismatch("beat with nothing pending", m_tdata[63:0], 64'd0);
        end else begin
            want = finished_q.pop_front();
            if (m_tdata[P_LO-1:0] != want.channel)
                report_mismatch("channel", 64'(m_tdata[P_LO-1:0]), 64'(want.channel));
            if (m_tdata[S_LO-1:P_LO] != want.pitch)
                report_mismatch("pitch", 64'(m_tdata[S_LO-1:P_LO]), 64'(want.pitch));
            if (m_tdata[E_LO-1:S_LO] != want.start_time)
                report_mismatch("start_time", 64'(m_tdata[E_LO-1:S_LO]),
                                64'(want.start_time));
            if (m_tdata[E_LO+OUT_TIME_W-1:E_LO] != want.end_time)
                report_mismatch("end_time", 64'(m_tdata[E_LO+OUT_TIME_W-1:E_LO]),
                                64'(want.end_time));
            if (m_tuser != want.is_error)
                report_mismatch("is_error", 64'(m_tuser), 64'(want.is_error));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_track();
            finished_q.delete();
        end else begin
            if (s_tvalid && s_tready) absorb_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready) check_beat();
        end
        pending = finished_q.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import mte_pkg::*;

    localparam int ITEMS       = 1650;
    localparam int QUIET_AT    = 1450;
    localparam int STUCK_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    int                   mismatches;
    int                   pending;

    bit         quiet      = 1'b0;
    bit         idle_on    = 1'b0;
    bit         long_hold  = 1'b0;
    bit         track_head = 1'b0;
    int         sent       = 0;
    logic [7:0] gen_st     = '0;

    midi_track_note_extractor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    note_checker note_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_beat(input logic [7:0] b);
        if (!quiet && idle_on && $urandom_range(0, 6) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= b;
        s_tuser    <= track_head;
        track_head = 1'b0;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic send_varlen(input logic [34:0] v, input int nb);
        for (int i = nb - 1; i >= 0; i--) send_beat({i != 0, v[i*7 +: 7]});
    endtask

    task automatic send_delta();
        int          r;
        int          nb;
        logic [34:0] v;
        r = $urandom_range(0, 99);
        nb = (r < 60) ? 1 : (r < 85) ? 2 : (r < 93) ? 3 : (r < 97) ? 4 : 5;
        v = 35'($urandom());
        v[34:32] = 3'($urandom_range(0, 7));
        if (r < 30) v = '0;
        send_varlen(v, nb);
    endtask

    function automatic logic [7:0] pick_key();
        logic [7:0] k;
        if ($urandom_range(0, 4) != 0) k = 8'($urandom_range(60, 65));
        else k = 8'($urandom_range(0, 127));
        return k;
    endfunction

    function automatic logic [3:0] pick_ch();
        logic [3:0] c;
        if ($urandom_range(0, 3) != 0) c = 4'($urandom_range(0, 3));
        else c = 4'($urandom_range(0, 15));
        return c;
    endfunction

    task automatic send_body(input logic [7:0] st);
        int len;
        int r;
        if (st[7:4] == NIB_NOTE_OFF || st[7:4] == NIB_NOTE_ON) begin
            send_beat(pick_key());
            r = $urandom_range(0, 9);
            if (r < 3) send_beat(8'h00);
            else if (r < 8) send_beat(8'($urandom_range(1, 127)));
            else send_beat(8'($urandom_range(0, 255)));
        end else if (st[7:4] == NIB_POLY_PRESS || st[7:4] == NIB_CONTROL ||
                     st[7:4] == NIB_PITCH_BEND) begin
            send_beat(8'($urandom_range(0, 127)));
            send_beat(8'($urandom_range(0, 255)));
        end else if (st == ST_SYSEX) begin
            len = $urandom_range(0, 6);
            send_beat(8'(len));
            repeat (len) send_beat(8'($urandom_range(0, 255)));
        end else if (st == ST_META) begin
            send_beat(8'($urandom_range(0, 127)));
            r = $urandom_range(0, 9);
            if (r < 7) begin
                len = $urandom_range(0, 8);
                send_beat(8'(len));
            end else if (r < 9) begin
                len = 128 + $urandom_range(0, 16);
                send_varlen(35'(len), 2);
            end else begin
                // five-byte length whose top bits fall off the accumulator
                len = $urandom_range(0, 8);
                send_beat(8'(8'h80 | ($urandom_range(0, 7) << 4)));
                send_beat(8'h80);
                send_beat(8'h80);
                send_beat(8'h80);
                send_beat(8'(len));
            end
            repeat (len) send_beat(8'($urandom_range(0, 255)));
        end else begin
            send_beat(8'($urandom_range(0, 127)));
        end
    endtask

    task automatic start_track();
        track_head = 1'b1;
        gen_st     = '0;
        idle_on    = $urandom_range(0, 2) != 0;
    endtask

    task automatic random_track();
        int         events;
        int         e;
        int         r;
        logic [3:0] nib;
        logic [7:0] st;
        start_track();
        events = $urandom_range(3, 60);
        e = 0;
        while (e < events) begin
            send_delta();
            r = $urandom_range(0, 99);
            e++;
            if (r >= 42 && r < 62) begin
                send_body(gen_st);
            end else if (r < 90) begin
                if (r < 30) begin
                    st = {NIB_NOTE_ON, pick_ch()};
                end else if (r < 42) begin
                    st = {NIB_NOTE_OFF, pick_ch()};
                end else if (r < 72) begin
                    nib = 4'(NIB_POLY_PRESS + $urandom_range(0, 4));
                    st  = {nib, pick_ch()};
                end else if (r < 78) begin
                    st = ST_SYSEX;
                end else if (r < 86) begin
                    st = ST_META;
                end else begin
                    st = 8'(ST_SYSEX + $urandom_range(1, 14));
                end
                send_beat(st);
                gen_st = st;
                send_body(st);
            end else begin
                // broken event: a status without data, or raw noise; the track ends here
                if (r < 95) begin
                    send_beat(8'(8'h80 + $urandom_range(0, 127)));
                    send_beat(8'(8'h80 + $urandom_range(0, 127)));
                end
                repeat ($urandom_range(1, 4)) send_beat(8'($urandom_range(0, 255)));
                e = events;
            end
        end
    endtask

    // result sink
    initial begin
        int stall_left;
        int calm_left;
        bit stalls_on;
        bit held;
        m_tready <= 1'b0;
        stall_left = 0;
        calm_left  = 0;
        stalls_on  = 1'b1;
        held       = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold && !held) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                held = 1'b1;
            end else begin
                if (calm_left == 0) begin
                    stalls_on = $urandom_range(0, 3) != 0;
                    calm_left = $urandom_range(50, 300);
                end
                calm_left--;
                if (stall_left > 0) stall_left--;
                else if (!quiet && stalls_on && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 19);
                m_tready <= (stall_left == 0);
                @(posedge aclk);
            end
        end
    end

    initial begin
        int still;
        still = 0;
        while (still < STUCK_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) still = 0;
            else still++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        logic [3:0] ch;
        logic [7:0] k;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        aresetn  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed opening
        start_track();
        send_beat(8'h00); send_beat(8'h40);  // data with no running status is dropped
        send_beat(8'h00); send_beat({NIB_NOTE_ON, 4'h0}); send_beat(8'h3C); send_beat(8'h7F);
        send_beat(8'h81); send_beat(8'h00); send_beat(8'h3C); send_beat(8'h00);
        send_beat(8'h00); send_beat({NIB_NOTE_ON, 4'hF}); send_beat(8'h7F); send_beat(8'hFF);
        send_beat(8'h00); send_beat({NIB_NOTE_OFF, 4'hF}); send_beat(8'h7F); send_beat(8'h00);
        send_beat(8'h00); send_beat({NIB_NOTE_OFF, 4'h3}); send_beat(8'h11); send_beat(8'h40);
        send_beat(8'h00); send_beat({NIB_NOTE_ON, 4'h0}); send_beat(ST_META);
        send_beat(8'h55);  // halted

        // sink holds off while notes keep closing
        start_track();
        idle_on   = 1'b0;
        long_hold = 1'b1;
        repeat (24) begin
            ch = 4'($urandom_range(0, 15));
            k  = pick_key();
            send_beat(8'h00); send_beat({NIB_NOTE_ON, ch}); send_beat(k);
            send_beat(8'($urandom_range(1, 255)));
            send_beat(8'h00); send_beat(k); send_beat(8'h00);
        end

        // a note left open must not survive hundreds of track starts
        start_track();
        send_beat(8'h00); send_beat({NIB_NOTE_ON, 4'h1}); send_beat(8'h05); send_beat(8'h40);
        repeat (260) begin
            track_head = 1'b1;
            send_beat(8'($urandom_range(0, 255)));
        end
        start_track();
        send_beat(8'h00); send_beat({NIB_NOTE_OFF, 4'h1}); send_beat(8'h05); send_beat(8'h00);

        while (sent < ITEMS) begin
            quiet = sent >= QUIET_AT;
            random_track();
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/mte_pkg.sv
rtl/core/mte_ram.sv
rtl/core/mte_table.sv
rtl/core/mte_parser.sv
rtl/core/mte_out_buf.sv
rtl/core/midi_track_note_extractor.sv
tb/note_checker.sv
tb/tb_top.sv
